// ===== hdl/gfwg_pkg.sv =====
package gfwg_pkg;

   localparam int HDR_BYTES = 86;
   localparam int HDR_WORDS = 11;
   localparam int LEN_W = 16;
   localparam int FLEN_W = 12;

   localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
   localparam logic [7:0] IP_VER_IHL = 8'h45;
   localparam logic [7:0] IP_TTL = 8'd64;
   localparam logic [7:0] IP_PROTO_UDP = 8'd17;
   localparam logic [15:0] OUTER_IP_ID = 16'd0;
   localparam logic [15:0] INNER_IP_ID = 16'd1234;
   localparam logic [15:0] OUTER_UDP_SRC_PORT = 16'd12345;
   localparam logic [15:0] GTPU_UDP_PORT = 16'd2152;
   localparam logic [7:0] GTPU_FLAGS = 8'h34;
   localparam logic [7:0] GTPU_MSG_TPDU = 8'hFF;
   localparam logic [7:0] GTPU_EXT_PDU_SESSION = 8'h85;
   localparam logic [7:0] PDU_EXT_LENGTH = 8'h01;
   localparam logic [7:0] PDU_TYPE_UL = 8'h10;

   localparam logic [15:0] OUTER_IP_EXTRA = 16'd44;
   localparam logic [15:0] OUTER_UDP_EXTRA = 16'd52;
   localparam logic [15:0] GTPU_LEN_EXTRA = 16'd36;
   localparam logic [15:0] INNER_IP_EXTRA = 16'd28;
   localparam logic [15:0] INNER_UDP_EXTRA = 16'd8;
   localparam logic [15:0] IP_HDR_BYTES_EXTRA = 16'd28;

   localparam logic [7:0] SOURCE_MAC_RESET = 8'd0;
   localparam logic [31:0] INNER_SOURCE_IP_RESET = 32'h0A00_0001;
   localparam logic [31:0] INNER_DEST_IP_RESET = 32'h0808_0808;
   localparam logic [10:0] PAYLOAD_LENGTH_RESET = 11'd1024;
   localparam logic [7:0] FILL_BYTE_RESET = 8'h41;

   typedef enum logic [2:0] {
      CSR_SOURCE_MAC = 3'd0,
      CSR_DEST_MAC = 3'd1,
      CSR_OUTER_SOURCE_IP = 3'd2,
      CSR_OUTER_DEST_IP = 3'd3,
      CSR_INNER_SOURCE_IP = 3'd4,
      CSR_INNER_DEST_IP = 3'd5,
      CSR_PAYLOAD_LENGTH = 3'd6,
      CSR_FILL_BYTE = 3'd7
   } csr_index_type;

   function automatic logic [15:0] ip_checksum(
      input logic [15:0] total,
      input logic [15:0] ident,
      input logic [31:0] src,
      input logic [31:0] dst
   );
      logic [19:0] sum;
      logic [16:0] fold;
      logic [15:0] res;
      sum = 20'({IP_VER_IHL, 8'h00}) + 20'(total) + 20'(ident)
         + 20'({IP_TTL, IP_PROTO_UDP}) + 20'(src[31:16]) + 20'(src[15:0])
         + 20'(dst[31:16]) + 20'(dst[15:0]);
      fold = 17'(sum[19:16]) + 17'(sum[15:0]);
      res = fold[15:0] + 16'(fold[16]);
      return ~res;
   endfunction

endpackage

// ===== hdl/gtpu_frame_word_generator_core.sv =====
// Channel     | Ports                         | Moves
// ------------+-------------------------------+------------------------------------------
// request     | req_valid / req_ready / req_* | flow fields and word index
// response    | rsp_valid / rsp_ready / rsp_* | one frame word with byte count and flags
// csr         | csr_psel ... csr_pready       | APB registers at byte address 8*index
//
// Each request yields one response, which passes through an input
// register, then the header build, checksums and word select, then the response register.
// A new request is accepted every cycle while responses are taken.
// A stalled response holds in its register while one more request waits in the input
// register; the checksum adder tree sets the clock period.
// Reset is synchronous and active high; it empties both stages and loads the register defaults.
module gtpu_frame_word_generator_core #(
   parameter int MAX_FRAME_BYTES = 1514
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_tunnel_id,
   input  logic [5:0]  req_flow_qos_id,
   input  logic [15:0] req_inner_source_port,
   input  logic [15:0] req_inner_dest_port,
   input  logic [7:0]  req_word_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_frame_word,
   output logic [3:0]  rsp_valid_bytes,
   output logic        rsp_last_word,
   output logic        rsp_past_end,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [15:0] PLEN_MAX = 16'(MAX_FRAME_BYTES - gfwg_pkg::HDR_BYTES);
   localparam logic [gfwg_pkg::FLEN_W-1:0] FLEN_W_HDR = gfwg_pkg::FLEN_W'(gfwg_pkg::HDR_BYTES);

   logic [47:0] source_mac_ff;
   logic [47:0] dest_mac_ff;
   logic [31:0] outer_source_ip_ff;
   logic [31:0] outer_dest_ip_ff;
   logic [31:0] inner_source_ip_ff;
   logic [31:0] inner_dest_ip_ff;
   logic [10:0] payload_length_ff;
   logic [7:0]  fill_byte_ff;

   logic        s1_valid_ff;
   logic        s1_valid_in;
   logic [31:0] s1_tunnel_id_ff;
   logic [5:0]  s1_flow_qos_id_ff;
   logic [15:0] s1_source_port_ff;
   logic [15:0] s1_dest_port_ff;
   logic [7:0]  s1_word_index_ff;

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [63:0] frame_word_ff;
   logic [63:0] frame_word_in;
   logic [3:0]  valid_bytes_ff;
   logic [3:0]  valid_bytes_in;
   logic        last_word_ff;
   logic        last_word_in;
   logic        past_end_ff;
   logic        past_end_in;

   logic        csr_write;
   gfwg_pkg::csr_index_type csr_index;
   logic        req_accept;
   logic        s2_load;

   logic [10:0] plen_sat;
   logic [15:0] plen_ext;
   logic [15:0] outer_ip_len;
   logic [15:0] inner_ip_len;
   logic [15:0] outer_csum;
   logic [15:0] inner_csum;
   logic [gfwg_pkg::HDR_WORDS*64-1:0] hdr_vec;
   logic [63:0] hdr_words [gfwg_pkg::HDR_WORDS];
   logic [63:0] raw_word;
   logic [gfwg_pkg::FLEN_W-1:0] frame_len;
   logic [gfwg_pkg::FLEN_W-1:0] base;
   logic [gfwg_pkg::FLEN_W-1:0] remain;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index = gfwg_pkg::csr_index_type'(csr_paddr[5:3]);

   always_comb begin
      unique case (csr_index)
         gfwg_pkg::CSR_SOURCE_MAC: csr_prdata = 64'(source_mac_ff);
         gfwg_pkg::CSR_DEST_MAC: csr_prdata = 64'(dest_mac_ff);
         gfwg_pkg::CSR_OUTER_SOURCE_IP: csr_prdata = 64'(outer_source_ip_ff);
         gfwg_pkg::CSR_OUTER_DEST_IP: csr_prdata = 64'(outer_dest_ip_ff);
         gfwg_pkg::CSR_INNER_SOURCE_IP: csr_prdata = 64'(inner_source_ip_ff);
         gfwg_pkg::CSR_INNER_DEST_IP: csr_prdata = 64'(inner_dest_ip_ff);
         gfwg_pkg::CSR_PAYLOAD_LENGTH: csr_prdata = 64'(payload_length_ff);
         gfwg_pkg::CSR_FILL_BYTE: csr_prdata = 64'(fill_byte_ff);
         default: csr_prdata = 64'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_mac_ff <= 48'(gfwg_pkg::SOURCE_MAC_RESET);
         dest_mac_ff <= 48'(gfwg_pkg::SOURCE_MAC_RESET);
         outer_source_ip_ff <= 32'd0;
         outer_dest_ip_ff <= 32'd0;
         inner_source_ip_ff <= gfwg_pkg::INNER_SOURCE_IP_RESET;
         inner_dest_ip_ff <= gfwg_pkg::INNER_DEST_IP_RESET;
         payload_length_ff <= gfwg_pkg::PAYLOAD_LENGTH_RESET;
         fill_byte_ff <= gfwg_pkg::FILL_BYTE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            gfwg_pkg::CSR_SOURCE_MAC: source_mac_ff <= csr_pwdata[47:0];
            gfwg_pkg::CSR_DEST_MAC: dest_mac_ff <= csr_pwdata[47:0];
            gfwg_pkg::CSR_OUTER_SOURCE_IP: outer_source_ip_ff <= csr_pwdata[31:0];
            gfwg_pkg::CSR_OUTER_DEST_IP: outer_dest_ip_ff <= csr_pwdata[31:0];
            gfwg_pkg::CSR_INNER_SOURCE_IP: inner_source_ip_ff <= csr_pwdata[31:0];
            gfwg_pkg::CSR_INNER_DEST_IP: inner_dest_ip_ff <= csr_pwdata[31:0];
            gfwg_pkg::CSR_PAYLOAD_LENGTH: payload_length_ff <= csr_pwdata[10:0];
            gfwg_pkg::CSR_FILL_BYTE: fill_byte_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   assign s2_load = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s2_load;
   assign req_accept = req_valid && req_ready;
   assign s1_valid_in = req_accept || (s1_valid_ff && !s2_load);
   assign rsp_valid_in = s2_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_tunnel_id_ff <= req_tunnel_id;
         s1_flow_qos_id_ff <= req_flow_qos_id;
         s1_source_port_ff <= req_inner_source_port;
         s1_dest_port_ff <= req_inner_dest_port;
         s1_word_index_ff <= req_word_index;
      end
      if (s2_load) begin
         frame_word_ff <= frame_word_in;
         valid_bytes_ff <= valid_bytes_in;
         last_word_ff <= last_word_in;
         past_end_ff <= past_end_in;
      end
   end

   // Oversized payload lengths are clipped so that the frame never exceeds its maximum.
   always_comb begin
      if (16'(payload_length_ff) > PLEN_MAX) begin
         plen_sat = PLEN_MAX[10:0];
      end else begin
         plen_sat = payload_length_ff;
      end
   end

   assign plen_ext = 16'(plen_sat);
   assign outer_ip_len = gfwg_pkg::OUTER_IP_EXTRA + gfwg_pkg::IP_HDR_BYTES_EXTRA + plen_ext;
   assign inner_ip_len = gfwg_pkg::INNER_IP_EXTRA + plen_ext;
   assign outer_csum = gfwg_pkg::ip_checksum(outer_ip_len, gfwg_pkg::OUTER_IP_ID,
                                             outer_source_ip_ff, outer_dest_ip_ff);
   assign inner_csum = gfwg_pkg::ip_checksum(inner_ip_len, gfwg_pkg::INNER_IP_ID,
                                             inner_source_ip_ff, inner_dest_ip_ff);

   // The header occupies the first eleven words; its last two bytes are payload.
   assign hdr_vec = {
      dest_mac_ff, source_mac_ff, gfwg_pkg::ETH_TYPE_IPV4,
      gfwg_pkg::IP_VER_IHL, 8'h00, outer_ip_len, gfwg_pkg::OUTER_IP_ID, 16'h0000,
      gfwg_pkg::IP_TTL, gfwg_pkg::IP_PROTO_UDP, outer_csum,
      outer_source_ip_ff, outer_dest_ip_ff,
      gfwg_pkg::OUTER_UDP_SRC_PORT, gfwg_pkg::GTPU_UDP_PORT,
      gfwg_pkg::OUTER_UDP_EXTRA + plen_ext, 16'h0000,
      gfwg_pkg::GTPU_FLAGS, gfwg_pkg::GTPU_MSG_TPDU, gfwg_pkg::GTPU_LEN_EXTRA + plen_ext,
      s1_tunnel_id_ff, 8'h00, 8'h00, 8'h00, gfwg_pkg::GTPU_EXT_PDU_SESSION,
      gfwg_pkg::PDU_EXT_LENGTH, gfwg_pkg::PDU_TYPE_UL, {2'b00, s1_flow_qos_id_ff}, 8'h00,
      gfwg_pkg::IP_VER_IHL, 8'h00, inner_ip_len, gfwg_pkg::INNER_IP_ID, 16'h0000,
      gfwg_pkg::IP_TTL, gfwg_pkg::IP_PROTO_UDP, inner_csum,
      inner_source_ip_ff, inner_dest_ip_ff,
      s1_source_port_ff, s1_dest_port_ff, gfwg_pkg::INNER_UDP_EXTRA + plen_ext, 16'h0000,
      fill_byte_ff, fill_byte_ff
   };

   always_comb begin
      for (int w = 0; w < gfwg_pkg::HDR_WORDS; w++) begin
         hdr_words[w] = hdr_vec[(gfwg_pkg::HDR_WORDS - w) * 64 - 1 -: 64];
      end
   end

   always_comb begin
      if (s1_word_index_ff < 8'(gfwg_pkg::HDR_WORDS)) begin
         raw_word = hdr_words[s1_word_index_ff[3:0]];
      end else begin
         raw_word = {8{fill_byte_ff}};
      end
   end

   assign frame_len = FLEN_W_HDR + {1'b0, plen_sat};
   assign base = {1'b0, s1_word_index_ff, 3'b000};
   assign remain = frame_len - base;

   always_comb begin
      past_end_in = (base >= frame_len);
      last_word_in = 1'b0;
      valid_bytes_in = 4'd0;
      frame_word_in = 64'd0;
      if (!past_end_in) begin
         last_word_in = ((base + gfwg_pkg::FLEN_W'(8)) >= frame_len);
         if (remain > gfwg_pkg::FLEN_W'(8)) begin
            valid_bytes_in = 4'd8;
         end else begin
            valid_bytes_in = remain[3:0];
         end
         for (int i = 0; i < 8; i++) begin
            if (4'(i) < valid_bytes_in) begin
               frame_word_in[63 - 8 * i -: 8] = raw_word[63 - 8 * i -: 8];
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_frame_word = frame_word_ff;
   assign rsp_valid_bytes = valid_bytes_ff;
   assign rsp_last_word = last_word_ff;
   assign rsp_past_end = past_end_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && past_end_ff |-> valid_bytes_ff == 4'd0 && !last_word_ff
                                       && frame_word_ff == 64'd0)
      else $error("Past-end response carries data.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !past_end_ff |-> valid_bytes_ff != 4'd0 && valid_bytes_ff <= 4'd8)
      else $error("In-frame response has an invalid byte count.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !last_word_ff && !past_end_ff |-> valid_bytes_ff == 4'd8)
      else $error("Non-final word is not full.");

   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_load |=> s1_valid_ff && $stable(s1_word_index_ff))
      else $error("Held request was lost or overwritten.");

endmodule
